// ----- sv/rirt_pkg.sv -----
// Package for the removed index remap table.
// Holds the request type codes shared by the channel interface and the top level.
package rirt_pkg;

  typedef enum logic {
    REQ_MAP   = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

endpackage

// ----- sv/rirt_in_if.sv -----
// Request channel of the removed index remap table.
// Depends on rirt_pkg for the request type.
interface rirt_in_if #(
  parameter int INDEX_BITS = 16
);
  logic                   valid;
  logic                   ready;
  rirt_pkg::req_type_t    req_type;
  logic [INDEX_BITS-1:0]  current_index;
  logic                   last_in_batch;

  modport source (output valid, output req_type, output current_index,
                  output last_in_batch, input ready);
  modport sink   (input valid, input req_type, input current_index,
                  input last_in_batch, output ready);
endinterface

// ----- sv/rirt_out_if.sv -----
// Result channel of the removed index remap table.
// Stand-alone; carries the mapped index and the batch drop flag.
interface rirt_out_if #(
  parameter int INDEX_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_BITS-1:0]  original_index;
  logic                   batch_dropped;

  modport source (output valid, output original_index, output batch_dropped,
                  input ready);
  modport sink   (input valid, input original_index, input batch_dropped,
                  output ready);
endinterface

// ----- sv/rirt_ram.sv -----
// Simple dual-port memory: one write and one registered read per cycle.
// Used for the removed table and the pending batch buffer.
module rirt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rirt_cmp_unit.sv -----
// Shared compare and saturating increment unit.
// Serves both the map walk and the sorted insertion shift loop.
module rirt_cmp_unit #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] lhs,
  input  logic [WIDTH-1:0] rhs,
  output logic             gt,
  output logic [WIDTH-1:0] rhs_inc
);

  assign gt      = lhs > rhs;
  assign rhs_inc = (rhs == {WIDTH{1'b1}}) ? rhs : rhs + WIDTH'(1);

endmodule

// ----- sv/removed_index_remap_table.sv -----
// Top level of the removed index remap table: sequencer, counters and output register.
// Depends on rirt_pkg, rirt_in_if, rirt_out_if, rirt_ram and rirt_cmp_unit.
//
//   channel  dir  payload                                  handshake
//   req      in   req_type, current_index, last_in_batch   valid/ready
//   res      out  original_index, batch_dropped            valid/ready
//
// A clear item empties the table when it is accepted. A map item walks k table entries
// (k at most the table fill), one table memory read per cycle, then stores its result.
// After a recorded batch that is not dropped, each pending index is loaded, read, compared
// against c entries while shifting up (c at most one more than shifted) and then put.
// req.ready is high only between items.
// The result stays in an output register; a full register stalls the next result.
// Reset clears the state, counts, overflow flag and output valid; memories hold garbage until written.
module removed_index_remap_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int INDEX_BITS  = 16,
  parameter int BATCH_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  rirt_in_if.sink    req,
  rirt_out_if.source res
);
  import rirt_pkg::*;

  localparam int TA  = $clog2(TABLE_DEPTH);
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int PA  = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int PCW = $clog2(BATCH_DEPTH + 1);
  localparam int SW  = ((TCW > PCW) ? TCW : PCW) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MAP_CMP  = 3'd1;
  localparam logic [2:0] S_STORE    = 3'd2;
  localparam logic [2:0] S_INS_LOAD = 3'd3;
  localparam logic [2:0] S_INS_VAL  = 3'd4;
  localparam logic [2:0] S_INS_CMP  = 3'd5;
  localparam logic [2:0] S_INS_PUT  = 3'd6;

  logic [2:0]            state, state_next;
  logic [TCW-1:0]        table_count, table_count_next;
  logic [PCW-1:0]        pending_count, pending_count_next;
  logic                  pending_overflow, pending_overflow_next;
  logic [TA-1:0]         walk_ptr, walk_ptr_next;
  logic [INDEX_BITS-1:0] value, value_next;
  logic                  last, last_next;
  logic [PCW-1:0]        ins_i, ins_i_next;
  logic [TCW-1:0]        pos, pos_next;
  logic [INDEX_BITS-1:0] ins_v, ins_v_next;
  logic                  out_valid, out_valid_next;
  logic [INDEX_BITS-1:0] out_index, out_index_next;
  logic                  out_drop, out_drop_next;

  // Number of pending indices of the batch just ended, captured at its last item.
  logic [PCW-1:0]        pcount_new_at_end;

  logic                  tbl_we;
  logic [TA-1:0]         tbl_waddr, tbl_raddr;
  logic [INDEX_BITS-1:0] tbl_wdata, tbl_rdata;
  logic                  pnd_we;
  logic [INDEX_BITS-1:0] pnd_rdata;

  logic                  cmp_gt;
  logic [INDEX_BITS-1:0] cmp_rhs, cmp_inc;

  logic                  out_free;
  logic                  pnd_full;
  logic [PCW-1:0]        pcount_new;
  logic                  ovf_new;
  logic                  drop;
  logic [TCW-1:0]        pos_dec;

  rirt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (INDEX_BITS),
    .AW    (TA)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rirt_ram #(
    .DEPTH (BATCH_DEPTH),
    .WIDTH (INDEX_BITS),
    .AW    (PA)
  ) u_pending (
    .clk   (clk),
    .we    (pnd_we),
    .waddr (pending_count[PA-1:0]),
    .wdata (value),
    .raddr (ins_i[PA-1:0]),
    .rdata (pnd_rdata)
  );

  rirt_cmp_unit #(
    .WIDTH (INDEX_BITS)
  ) u_cmp (
    .lhs     (tbl_rdata),
    .rhs     (cmp_rhs),
    .gt      (cmp_gt),
    .rhs_inc (cmp_inc)
  );

  assign cmp_rhs   = (state == S_INS_CMP) ? ins_v : value;
  assign out_free  = !out_valid || res.ready;
  assign pnd_full  = pending_count >= PCW'(BATCH_DEPTH);
  assign pcount_new = pnd_full ? pending_count : pending_count + PCW'(1);
  assign ovf_new   = pending_overflow || pnd_full;
  assign drop      = ovf_new ||
                     (SW'(table_count) + SW'(pcount_new) > SW'(TABLE_DEPTH));
  assign pos_dec   = pos - TCW'(1);
  assign req.ready = (state == S_IDLE);

  assign tbl_waddr = pos[TA-1:0];
  assign tbl_wdata = (state == S_INS_PUT) ? ins_v : tbl_rdata;
  assign pnd_we    = (state == S_STORE) && out_free && !pnd_full;

  assign res.valid          = out_valid;
  assign res.original_index = out_index;
  assign res.batch_dropped  = out_drop;

  always_comb begin
    state_next            = state;
    table_count_next      = table_count;
    pending_count_next    = pending_count;
    pending_overflow_next = pending_overflow;
    walk_ptr_next         = walk_ptr;
    value_next            = value;
    last_next             = last;
    ins_i_next            = ins_i;
    pos_next              = pos;
    ins_v_next            = ins_v;
    out_valid_next        = out_valid && !res.ready;
    out_index_next        = out_index;
    out_drop_next         = out_drop;
    tbl_we                = 1'b0;
    tbl_raddr             = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_CLEAR) begin
            table_count_next      = '0;
            pending_count_next    = '0;
            pending_overflow_next = 1'b0;
          end else begin
            value_next    = req.current_index;
            last_next     = req.last_in_batch;
            walk_ptr_next = '0;
            state_next    = (table_count == '0) ? S_STORE : S_MAP_CMP;
          end
        end
      end
      S_MAP_CMP: begin
        // The walk stops at the first entry above the running value.
        if (cmp_gt) begin
          state_next = S_STORE;
        end else begin
          value_next = cmp_inc;
          if (TCW'(walk_ptr) + TCW'(1) < table_count) begin
            walk_ptr_next = walk_ptr + TA'(1);
            tbl_raddr     = walk_ptr + TA'(1);
          end else begin
            state_next = S_STORE;
          end
        end
      end
      S_STORE: begin
        if (out_free) begin
          out_valid_next        = 1'b1;
          out_index_next        = value;
          out_drop_next         = last && drop;
          pending_count_next    = pcount_new;
          pending_overflow_next = ovf_new;
          state_next            = S_IDLE;
          if (last) begin
            pending_count_next    = '0;
            pending_overflow_next = 1'b0;
            ins_i_next            = '0;
            if (!drop) begin
              state_next = S_INS_LOAD;
            end
          end
        end
      end
      S_INS_LOAD: begin
        state_next = S_INS_VAL;
      end
      S_INS_VAL: begin
        ins_v_next = pnd_rdata;
        pos_next   = table_count;
        tbl_raddr  = pos_dec[TA-1:0];
        if (table_count == '0) begin
          state_next = S_INS_PUT;
        end else begin
          tbl_raddr  = TA'(table_count - TCW'(1));
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // Entries above the new value move up one slot; equal ones stay below it.
        if (cmp_gt) begin
          tbl_we    = 1'b1;
          pos_next  = pos_dec;
          tbl_raddr = TA'(pos_dec - TCW'(1));
          if (pos_dec == '0) begin
            state_next = S_INS_PUT;
          end
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        tbl_we           = 1'b1;
        table_count_next = table_count + TCW'(1);
        ins_i_next       = ins_i + PCW'(1);
        if (ins_i + PCW'(1) < pcount_new_at_end) begin
          state_next = S_INS_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_STORE && out_free && last) begin
      pcount_new_at_end <= pcount_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      table_count      <= '0;
      pending_count    <= '0;
      pending_overflow <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      table_count      <= table_count_next;
      pending_count    <= pending_count_next;
      pending_overflow <= pending_overflow_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_ptr  <= walk_ptr_next;
    value     <= value_next;
    last      <= last_next;
    ins_i     <= ins_i_next;
    pos       <= pos_next;
    ins_v     <= ins_v_next;
    out_index <= out_index_next;
    out_drop  <= out_drop_next;
  end

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    table_count <= TCW'(TABLE_DEPTH))
    else $error("table count exceeds table depth");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= PCW'(BATCH_DEPTH))
    else $error("pending count exceeds batch depth");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP) |-> (pos != '0))
    else $error("insertion shift below the first slot");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_CLEAR) |=>
      (table_count == '0 && pending_count == '0 && !pending_overflow))
    else $error("clear did not empty the table");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_STORE))
    else $error("result raised outside the store step");

endmodule
